// ===== hdl/ksd_pkg.sv =====
// ============================================================================
// Keyboard scancode decoder package
// Shared constants, key tables, state record and result record for the
// scancode-set-1 keyboard decoder.
// ============================================================================
package ksd_pkg;

    // Widths of the transaction fields.
    localparam int SCAN_W    = 8;
    localparam int MAKE_W    = 7;
    localparam int KEY_W     = 9;
    localparam int MOD_W     = 6;
    localparam int COUNT_W   = 32;
    localparam int KEYMAP_W  = 2 * KEY_W;

    // Raw scancodes with a fixed meaning.
    localparam logic [SCAN_W-1:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [MAKE_W-1:0] SC_LSHIFT     = 7'h2A;
    localparam logic [MAKE_W-1:0] SC_RSHIFT     = 7'h36;
    localparam logic [MAKE_W-1:0] SC_CTRL       = 7'h1D;
    localparam logic [MAKE_W-1:0] SC_ALT        = 7'h38;
    localparam logic [MAKE_W-1:0] SC_CAPS_LOCK  = 7'h3A;
    localparam logic [MAKE_W-1:0] SC_NUM_LOCK   = 7'h45;
    localparam logic [MAKE_W-1:0] SC_LSUPER     = 7'h5B;
    localparam logic [MAKE_W-1:0] SC_RSUPER     = 7'h5C;

    // Make codes that change meaning after the extended prefix.
    localparam logic [MAKE_W-1:0] SC_EXT_UP     = 7'h48;
    localparam logic [MAKE_W-1:0] SC_EXT_DOWN   = 7'h50;
    localparam logic [MAKE_W-1:0] SC_EXT_LEFT   = 7'h4B;
    localparam logic [MAKE_W-1:0] SC_EXT_RIGHT  = 7'h4D;
    localparam logic [MAKE_W-1:0] SC_EXT_HOME   = 7'h47;
    localparam logic [MAKE_W-1:0] SC_EXT_END    = 7'h4F;
    localparam logic [MAKE_W-1:0] SC_EXT_PGUP   = 7'h49;
    localparam logic [MAKE_W-1:0] SC_EXT_PGDN   = 7'h51;
    localparam logic [MAKE_W-1:0] SC_EXT_INS    = 7'h52;
    localparam logic [MAKE_W-1:0] SC_EXT_DEL    = 7'h53;
    localparam logic [MAKE_W-1:0] SC_EXT_ENTER  = 7'h1C;
    localparam logic [MAKE_W-1:0] SC_EXT_SLASH  = 7'h35;

    // Special key codes.
    localparam logic [KEY_W-1:0] KEY_NONE        = 9'h000;
    localparam logic [KEY_W-1:0] KEY_ESC         = 9'h100;
    localparam logic [KEY_W-1:0] KEY_BKSP        = 9'h101;
    localparam logic [KEY_W-1:0] KEY_TAB         = 9'h102;
    localparam logic [KEY_W-1:0] KEY_RETURN      = 9'h103;
    localparam logic [KEY_W-1:0] KEY_F1          = 9'h104;
    localparam logic [KEY_W-1:0] KEY_F2          = 9'h105;
    localparam logic [KEY_W-1:0] KEY_F3          = 9'h106;
    localparam logic [KEY_W-1:0] KEY_F4          = 9'h107;
    localparam logic [KEY_W-1:0] KEY_F5          = 9'h108;
    localparam logic [KEY_W-1:0] KEY_F6          = 9'h109;
    localparam logic [KEY_W-1:0] KEY_F7          = 9'h10A;
    localparam logic [KEY_W-1:0] KEY_F8          = 9'h10B;
    localparam logic [KEY_W-1:0] KEY_F9          = 9'h10C;
    localparam logic [KEY_W-1:0] KEY_F10         = 9'h10D;
    localparam logic [KEY_W-1:0] KEY_F11         = 9'h10E;
    localparam logic [KEY_W-1:0] KEY_F12         = 9'h10F;
    localparam logic [KEY_W-1:0] KEY_NAV_HOME    = 9'h110;
    localparam logic [KEY_W-1:0] KEY_ARROW_UP    = 9'h111;
    localparam logic [KEY_W-1:0] KEY_PGUP        = 9'h112;
    localparam logic [KEY_W-1:0] KEY_ARROW_LEFT  = 9'h113;
    localparam logic [KEY_W-1:0] KEY_ARROW_RIGHT = 9'h114;
    localparam logic [KEY_W-1:0] KEY_END         = 9'h115;
    localparam logic [KEY_W-1:0] KEY_ARROW_DOWN  = 9'h116;
    localparam logic [KEY_W-1:0] KEY_PGDN        = 9'h117;
    localparam logic [KEY_W-1:0] KEY_INS         = 9'h118;
    localparam logic [KEY_W-1:0] KEY_DEL         = 9'h119;
    localparam logic [KEY_W-1:0] KEY_LAST        = KEY_DEL;

    // ASCII bounds used for case folding and console codes.
    localparam logic [KEY_W-1:0] CHR_LOWER_A = 9'h061;
    localparam logic [KEY_W-1:0] CHR_LOWER_Z = 9'h07A;
    localparam logic [KEY_W-1:0] CHR_UPPER_A = 9'h041;
    localparam logic [KEY_W-1:0] CHR_UPPER_Z = 9'h05A;
    localparam logic [KEY_W-1:0] CHR_SLASH   = 9'h02F;
    localparam logic [KEY_W-1:0] CASE_DELTA  = CHR_LOWER_A - CHR_UPPER_A;
    localparam logic [KEY_W-1:0] CONSOLE_MAX = 9'd26;

    // Modifier masks.
    localparam logic [MOD_W-1:0] M_SHIFT = 6'b000001;
    localparam logic [MOD_W-1:0] M_CTRL  = 6'b000010;
    localparam logic [MOD_W-1:0] M_ALT   = 6'b000100;
    localparam logic [MOD_W-1:0] M_SUPER = 6'b001000;
    localparam logic [MOD_W-1:0] M_CAPS  = 6'b010000;
    localparam logic [MOD_W-1:0] M_NUM   = 6'b100000;

    // Decoder state record, one entry of the state memory.
    typedef struct packed {
        logic [COUNT_W-1:0] press_count;
        logic               prefix;
        logic [MOD_W-1:0]   mods;
    } ksd_state_t;

    // One decoded key event.
    typedef struct packed {
        logic               key_released;
        logic [KEY_W-1:0]   key_code;
        logic [MOD_W-1:0]   modifier_flags;
        logic               console_valid;
        logic [KEY_W-1:0]   console_code;
        logic [COUNT_W-1:0] press_total;
    } ksd_result_t;

    // Unshifted key table.
    function automatic logic [KEY_W-1:0] plain_key(input logic [MAKE_W-1:0] make);
        logic [KEY_W-1:0] k;
        begin
            case (make)
                7'h01: k = KEY_ESC;
                7'h02: k = 9'h031;
                7'h03: k = 9'h032;
                7'h04: k = 9'h033;
                7'h05: k = 9'h034;
                7'h06: k = 9'h035;
                7'h07: k = 9'h036;
                7'h08: k = 9'h037;
                7'h09: k = 9'h038;
                7'h0A: k = 9'h039;
                7'h0B: k = 9'h030;
                7'h0C: k = 9'h02D;
                7'h0D: k = 9'h03D;
                7'h0E: k = KEY_BKSP;
                7'h0F: k = KEY_TAB;
                7'h10: k = 9'h071;
                7'h11: k = 9'h077;
                7'h12: k = 9'h065;
                7'h13: k = 9'h072;
                7'h14: k = 9'h074;
                7'h15: k = 9'h079;
                7'h16: k = 9'h075;
                7'h17: k = 9'h069;
                7'h18: k = 9'h06F;
                7'h19: k = 9'h070;
                7'h1A: k = 9'h05B;
                7'h1B: k = 9'h05D;
                7'h1C: k = KEY_RETURN;
                7'h1E: k = 9'h061;
                7'h1F: k = 9'h073;
                7'h20: k = 9'h064;
                7'h21: k = 9'h066;
                7'h22: k = 9'h067;
                7'h23: k = 9'h068;
                7'h24: k = 9'h06A;
                7'h25: k = 9'h06B;
                7'h26: k = 9'h06C;
                7'h27: k = 9'h03B;
                7'h28: k = 9'h027;
                7'h29: k = 9'h060;
                7'h2B: k = 9'h05C;
                7'h2C: k = 9'h07A;
                7'h2D: k = 9'h078;
                7'h2E: k = 9'h063;
                7'h2F: k = 9'h076;
                7'h30: k = 9'h062;
                7'h31: k = 9'h06E;
                7'h32: k = 9'h06D;
                7'h33: k = 9'h02C;
                7'h34: k = 9'h02E;
                7'h35: k = 9'h02F;
                7'h37: k = 9'h02A;
                7'h39: k = 9'h020;
                7'h3B: k = KEY_F1;
                7'h3C: k = KEY_F2;
                7'h3D: k = KEY_F3;
                7'h3E: k = KEY_F4;
                7'h3F: k = KEY_F5;
                7'h40: k = KEY_F6;
                7'h41: k = KEY_F7;
                7'h42: k = KEY_F8;
                7'h43: k = KEY_F9;
                7'h44: k = KEY_F10;
                7'h47: k = KEY_NAV_HOME;
                7'h48: k = KEY_ARROW_UP;
                7'h49: k = KEY_PGUP;
                7'h4A: k = 9'h02D;
                7'h4B: k = KEY_ARROW_LEFT;
                7'h4C: k = 9'h035;
                7'h4D: k = KEY_ARROW_RIGHT;
                7'h4E: k = 9'h02B;
                7'h4F: k = KEY_END;
                7'h50: k = KEY_ARROW_DOWN;
                7'h51: k = KEY_PGDN;
                7'h52: k = KEY_INS;
                7'h53: k = KEY_DEL;
                7'h57: k = KEY_F11;
                7'h58: k = KEY_F12;
                default: k = KEY_NONE;
            endcase
            return k;
        end
    endfunction

    // Shifted key table; only entries that differ from the plain table are listed.
    function automatic logic [KEY_W-1:0] shift_key(input logic [MAKE_W-1:0] make);
        logic [KEY_W-1:0] k;
        begin
            case (make)
                7'h02: k = 9'h021;
                7'h03: k = 9'h040;
                7'h04: k = 9'h023;
                7'h05: k = 9'h024;
                7'h06: k = 9'h025;
                7'h07: k = 9'h05E;
                7'h08: k = 9'h026;
                7'h09: k = 9'h02A;
                7'h0A: k = 9'h028;
                7'h0B: k = 9'h029;
                7'h0C: k = 9'h05F;
                7'h0D: k = 9'h02B;
                7'h10: k = 9'h051;
                7'h11: k = 9'h057;
                7'h12: k = 9'h045;
                7'h13: k = 9'h052;
                7'h14: k = 9'h054;
                7'h15: k = 9'h059;
                7'h16: k = 9'h055;
                7'h17: k = 9'h049;
                7'h18: k = 9'h04F;
                7'h19: k = 9'h050;
                7'h1A: k = 9'h07B;
                7'h1B: k = 9'h07D;
                7'h1E: k = 9'h041;
                7'h1F: k = 9'h053;
                7'h20: k = 9'h044;
                7'h21: k = 9'h046;
                7'h22: k = 9'h047;
                7'h23: k = 9'h048;
                7'h24: k = 9'h04A;
                7'h25: k = 9'h04B;
                7'h26: k = 9'h04C;
                7'h27: k = 9'h03A;
                7'h28: k = 9'h022;
                7'h29: k = 9'h07E;
                7'h2B: k = 9'h07C;
                7'h2C: k = 9'h05A;
                7'h2D: k = 9'h058;
                7'h2E: k = 9'h043;
                7'h2F: k = 9'h056;
                7'h30: k = 9'h042;
                7'h31: k = 9'h04E;
                7'h32: k = 9'h04D;
                7'h33: k = 9'h03C;
                7'h34: k = 9'h03E;
                7'h35: k = 9'h03F;
                default: k = plain_key(make);
            endcase
            return k;
        end
    endfunction

    // Extended-prefix remap of navigation keys, keypad enter and keypad slash.
    function automatic logic [KEY_W-1:0] remap_extended(input logic [MAKE_W-1:0] make,
                                                        input logic [KEY_W-1:0]  key);
        logic [KEY_W-1:0] k;
        begin
            case (make)
                SC_EXT_UP:    k = KEY_ARROW_UP;
                SC_EXT_DOWN:  k = KEY_ARROW_DOWN;
                SC_EXT_LEFT:  k = KEY_ARROW_LEFT;
                SC_EXT_RIGHT: k = KEY_ARROW_RIGHT;
                SC_EXT_HOME:  k = KEY_NAV_HOME;
                SC_EXT_END:   k = KEY_END;
                SC_EXT_PGUP:  k = KEY_PGUP;
                SC_EXT_PGDN:  k = KEY_PGDN;
                SC_EXT_INS:   k = KEY_INS;
                SC_EXT_DEL:   k = KEY_DEL;
                SC_EXT_ENTER: k = KEY_RETURN;
                SC_EXT_SLASH: k = CHR_SLASH;
                default:      k = key;
            endcase
            return k;
        end
    endfunction

endpackage

// ===== hdl/ksd_stream_if.sv =====
// ============================================================================
// Keyboard scancode decoder stream interfaces
// Valid/ready channels for raw scancodes and for decoded key events.
// ============================================================================

// Raw scancode channel.
interface ksd_scan_if;
    import ksd_pkg::*;

    logic              valid;
    logic              ready;
    logic [SCAN_W-1:0] scancode;

    modport source (output valid, output scancode, input ready);
    modport sink   (input valid, input scancode, output ready);
endinterface

// Decoded key event channel.
interface ksd_key_if;
    import ksd_pkg::*;

    logic               valid;
    logic               ready;
    logic               key_released;
    logic [KEY_W-1:0]   key_code;
    logic [MOD_W-1:0]   modifier_flags;
    logic               console_valid;
    logic [KEY_W-1:0]   console_code;
    logic [COUNT_W-1:0] press_total;

    modport source (output valid, output key_released, output key_code,
                    output modifier_flags, output console_valid, output console_code,
                    output press_total, input ready);
    modport sink   (input valid, input key_released, input key_code,
                    input modifier_flags, input console_valid, input console_code,
                    input press_total, output ready);
endinterface

// ===== hdl/ksd_keymap_rom.sv =====
// ============================================================================
// Keyboard scancode decoder key map ROM
// Synchronous ROM returning the shifted and plain key codes of a make code.
// ============================================================================
module ksd_keymap_rom
    import ksd_pkg::*;
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [MAKE_W-1:0]   rd_addr,
    output logic [KEYMAP_W-1:0] rd_data
);

    logic [KEYMAP_W-1:0] rd_data_reg;

    // Both table entries are read together; the decode stage picks one
    // once the shift state is known.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= {shift_key(rd_addr), plain_key(rd_addr)};
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/keyboard_scancode_decoder.sv =====
// ============================================================================
// Keyboard scancode decoder
// Decodes scancode-set-1 bytes into key events with modifiers and console codes.
// ============================================================================
// The decoder takes one scancode byte per clock and gives at most one key
// event per byte. A byte goes through two stages: when it is accepted, the
// key map ROM and the single-entry state memory (held modifiers, extended
// prefix and press count) are read; the decode stage then decodes it, and
// when it retires the new state is written back and any event is loaded
// into the output register, with the written record forwarded to the next
// byte so that back-to-back bytes see each other's effect. An event is
// valid in the output register once its byte retires, and the sustained
// rate is one byte per cycle while the input is not stalled. The input
// stalls only while the decode stage holds a byte that makes an event and
// the output register still holds an event the receiver has not taken.
// Bytes that cause no event (the extended prefix, modifier and lock keys,
// unmapped codes) give none. No clearing pass is needed after reset.
module keyboard_scancode_decoder
    import ksd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ksd_scan_if.sink   scan,
    ksd_key_if.source  keys
);

    // Handshake and stage control.
    logic                scan_fire;
    logic                dec_adv;
    logic                dec_valid_reg;
    logic [SCAN_W-1:0]   dec_code_reg;
    logic [KEYMAP_W-1:0] map_word;

    // State memory and forwarding path.
    ksd_state_t          state_mem [1];
    logic                state_written_reg;
    ksd_state_t          rd_state_reg;
    ksd_state_t          wr_state_reg;
    logic                fwd_reg;
    ksd_state_t          state_cur;
    ksd_state_t          state_next;

    // Decode results.
    logic                has_result;
    ksd_result_t         result;
    logic                out_valid_reg;
    ksd_result_t         out_res_reg;

    assign scan_fire  = scan.valid & scan.ready;
    assign dec_adv    = dec_valid_reg & (~has_result | ~out_valid_reg | keys.ready);
    assign scan.ready = ~dec_valid_reg | dec_adv;

    // Key map lookup issued at acceptance.
    ksd_keymap_rom u_keymap_rom (
        .clk     (clk),
        .rd_en   (scan_fire),
        .rd_addr (scan.scancode[MAKE_W-1:0]),
        .rd_data (map_word)
    );

    // State memory: read at acceptance, written when the decode stage retires.
    always_ff @(posedge clk)
    begin
        if (dec_adv)
        begin
            state_mem[0] <= state_next;
            wr_state_reg <= state_next;
        end
        if (scan_fire)
        begin
            rd_state_reg <= state_written_reg ? state_mem[0] : '0;
            dec_code_reg <= scan.scancode;
        end
    end

    // A read that coincides with a write returns the old record, so the
    // decode stage uses the written record instead.
    assign state_cur = fwd_reg ? wr_state_reg : rd_state_reg;

    // Decode of one scancode against the current state.
    always_comb
    begin
        logic              released;
        logic [MAKE_W-1:0] make;
        logic              shifted;
        logic [MOD_W-1:0]  modbit;
        logic [MOD_W-1:0]  lockbit;
        logic [KEY_W-1:0]  key;
        logic              caps;
        logic              is_lower;
        logic              is_upper;

        released = dec_code_reg[SCAN_W-1];
        make     = dec_code_reg[MAKE_W-1:0];
        shifted  = |(state_cur.mods & M_SHIFT);
        caps     = |(state_cur.mods & M_CAPS);
        modbit   = '0;
        lockbit  = '0;

        case (make)
            SC_LSHIFT:    modbit  = M_SHIFT;
            SC_RSHIFT:    modbit  = M_SHIFT;
            SC_CTRL:      modbit  = M_CTRL;
            SC_ALT:       modbit  = M_ALT;
            SC_LSUPER:    modbit  = M_SUPER;
            SC_RSUPER:    modbit  = M_SUPER;
            SC_CAPS_LOCK: lockbit = M_CAPS;
            SC_NUM_LOCK:  lockbit = M_NUM;
            default:      modbit  = '0;
        endcase

        // Table lookup, extended remap and caps lock case folding.
        key = shifted ? map_word[KEYMAP_W-1:KEY_W] : map_word[KEY_W-1:0];
        if (state_cur.prefix)
        begin
            key = remap_extended(make, key);
        end
        is_lower = (key >= CHR_LOWER_A) && (key <= CHR_LOWER_Z);
        is_upper = (key >= CHR_UPPER_A) && (key <= CHR_UPPER_Z);
        if (caps && is_lower)
        begin
            key = key - CASE_DELTA;
        end
        else if (caps && shifted && is_upper)
        begin
            key = key + CASE_DELTA;
        end
        is_lower = (key >= CHR_LOWER_A) && (key <= CHR_LOWER_Z);
        is_upper = (key >= CHR_UPPER_A) && (key <= CHR_UPPER_Z);

        state_next        = state_cur;
        has_result        = 1'b0;
        result            = '0;
        result.key_released   = released;
        result.key_code       = key;
        result.press_total    = state_cur.press_count;

        if (dec_code_reg == SC_EXT_PREFIX)
        begin
            state_next.prefix = 1'b1;
        end
        else if (modbit != '0)
        begin
            state_next.prefix = 1'b0;
            state_next.mods   = released ? (state_cur.mods & ~modbit)
                                         : (state_cur.mods | modbit);
        end
        else if (lockbit != '0)
        begin
            state_next.prefix = 1'b0;
            if (!released)
            begin
                state_next.mods = state_cur.mods ^ lockbit;
            end
        end
        else
        begin
            state_next.prefix = 1'b0;
            if (key != KEY_NONE)
            begin
                has_result = 1'b1;
                if (!released)
                begin
                    state_next.press_count = state_cur.press_count + 1'b1;
                    result.press_total     = state_next.press_count;
                    if (|(state_cur.mods & M_CTRL))
                    begin
                        if (is_lower)
                        begin
                            result.console_valid = 1'b1;
                            result.console_code  = key - (CHR_LOWER_A - 1'b1);
                        end
                        else if (is_upper)
                        begin
                            result.console_valid = 1'b1;
                            result.console_code  = key - (CHR_UPPER_A - 1'b1);
                        end
                    end
                    else
                    begin
                        result.console_valid = 1'b1;
                        result.console_code  = key;
                    end
                end
            end
        end
        result.modifier_flags = state_cur.mods;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (dec_adv && has_result)
        begin
            out_res_reg <= result;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg     <= 1'b0;
            state_written_reg <= 1'b0;
            fwd_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (scan_fire)
            begin
                dec_valid_reg <= 1'b1;
                fwd_reg       <= dec_adv;
            end
            else if (dec_adv)
            begin
                dec_valid_reg <= 1'b0;
            end
            if (dec_adv)
            begin
                state_written_reg <= 1'b1;
            end
            if (dec_adv && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (keys.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign keys.valid          = out_valid_reg;
    assign keys.key_released   = out_res_reg.key_released;
    assign keys.key_code       = out_res_reg.key_code;
    assign keys.modifier_flags = out_res_reg.modifier_flags;
    assign keys.console_valid  = out_res_reg.console_valid;
    assign keys.console_code   = out_res_reg.console_code;
    assign keys.press_total    = out_res_reg.press_total;

endmodule

// ===== hdl/ksd_checker.sv =====
// ============================================================================
// Keyboard scancode decoder checker
// Port-level assertions on the key event channel, bound to the top level.
// ============================================================================
module ksd_checker
    import ksd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               key_valid,
    input logic               key_ready,
    input logic               key_released,
    input logic [KEY_W-1:0]   key_code,
    input logic [MOD_W-1:0]   modifier_flags,
    input logic               console_valid,
    input logic [KEY_W-1:0]   console_code,
    input logic [COUNT_W-1:0] press_total
);

    logic               seen_reg;
    logic [COUNT_W-1:0] last_total_reg;

    // Track the press total of the last event transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_total_reg <= '0;
        end
        else if (key_valid && key_ready)
        begin
            seen_reg       <= 1'b1;
            last_total_reg <= press_total;
        end
    end

    // A stalled event holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_ready |=> key_valid &&
        $stable({key_released, key_code, modifier_flags, console_valid,
                 console_code, press_total}))
        else $error("key event changed while stalled");

    // Every event carries a mapped key code.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid |-> key_code != KEY_NONE && key_code <= KEY_LAST)
        else $error("key event with unmapped key code");

    // Releases carry no console code.
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_released |-> !console_valid && console_code == KEY_NONE)
        else $error("release event with console code");

    // Ctrl combinations give a letter index.
    a_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && console_valid && |(modifier_flags & M_CTRL) |->
        console_code != KEY_NONE && console_code <= CONSOLE_MAX)
        else $error("ctrl console code out of range");

    // The press total steps by one on each press and holds on a release.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && seen_reg |->
        press_total == COUNT_W'(last_total_reg + {{(COUNT_W-1){1'b0}}, !key_released}))
        else $error("press total out of sequence");

endmodule

bind keyboard_scancode_decoder ksd_checker u_ksd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .key_valid      (keys.valid),
    .key_ready      (keys.ready),
    .key_released   (keys.key_released),
    .key_code       (keys.key_code),
    .modifier_flags (keys.modifier_flags),
    .console_valid  (keys.console_valid),
    .console_code   (keys.console_code),
    .press_total    (keys.press_total)
);
